[hdl/pta_pkg.sv]
// shared constants, codes and control structs for the proximity tag aggregator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pta_pkg;

  localparam int SLOT_COUNT  = 32;
  localparam int LEVEL_COUNT = 4;

  localparam int SLOT_W    = $clog2(SLOT_COUNT);
  localparam int FILL_W    = $clog2(SLOT_COUNT + 1);
  localparam int LVL_W     = $clog2(LEVEL_COUNT);
  localparam int CNT_DEPTH = SLOT_COUNT * LEVEL_COUNT;
  localparam int CNT_AW    = $clog2(CNT_DEPTH);

  localparam int ID_W     = 16;
  localparam int LEVEL_W  = 8;
  localparam int FLAG_W   = 8;
  localparam int SEQ_W    = 32;
  localparam int COUNT_W  = 8;
  localparam int STATUS_W = 2;
  localparam int OUT_IDX_W = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
  localparam logic [FLAG_W-1:0]  OVF_MASK_RESET = 8'h01;

  localparam logic [STATUS_W-1:0] ST_EXISTING = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CLAIMED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic            start;
    logic            claim;
    logic [ID_W-1:0] tag_id;
  } scan_ctl_t;

  typedef struct packed {
    logic              done;
    logic              hit;
    logic              full;
    logic [SLOT_W-1:0] slot;
  } scan_res_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic              claim;
    logic [SLOT_W-1:0] slot;
    logic [LVL_W-1:0]  level;
    logic [FLAG_W-1:0] flags;
    logic [SEQ_W-1:0]  seq;
  } upd_ctl_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [FLAG_W-1:0]  flags;
    logic [SEQ_W-1:0]   seq;
  } upd_res_t;

  // slot number as reported on the result, low bits only
  function automatic logic [OUT_IDX_W-1:0] slot_out(logic [SLOT_W-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[OUT_IDX_W-1:0];
  endfunction

endpackage

[hdl/pta_key_scan.sv]
// key table with fill count and the shared key comparator, scanned one slot per cycle
// depends on pta_pkg
`timescale 1ns / 1ps

module pta_key_scan import pta_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  scan_ctl_t ctl_i,
  output scan_res_t res_o
);

  logic [ID_W-1:0]   key_mem [SLOT_COUNT];
  logic [ID_W-1:0]   key_rd_q;
  logic [SLOT_W-1:0] rd_idx_q;
  logic              rd_vld_q;
  logic              busy_q;
  logic [FILL_W-1:0] ptr_q;
  logic [FILL_W-1:0] fill_q;
  logic              hit;
  logic              miss;
  logic              issue;

  // slots are claimed in order and never freed, so slots below fill_q hold keys
  assign hit   = busy_q && rd_vld_q && (key_rd_q == ctl_i.tag_id);
  assign miss  = busy_q && !rd_vld_q && (ptr_q == fill_q);
  assign issue = busy_q && !hit && (ptr_q != fill_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      ptr_q    <= '0;
      fill_q   <= '0;
    end else begin
      if (ctl_i.start) begin
        busy_q   <= 1'b1;
        rd_vld_q <= 1'b0;
        ptr_q    <= '0;
      end else if (hit || miss) begin
        busy_q   <= 1'b0;
        rd_vld_q <= 1'b0;
      end else begin
        rd_vld_q <= issue;
        if (issue) begin
          ptr_q <= ptr_q + FILL_W'(1);
        end
      end
      if (ctl_i.claim) begin
        fill_q <= fill_q + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      key_rd_q <= key_mem[ptr_q[SLOT_W-1:0]];
      rd_idx_q <= ptr_q[SLOT_W-1:0];
    end
    if (ctl_i.claim) begin
      key_mem[fill_q[SLOT_W-1:0]] <= ctl_i.tag_id;
    end
  end

  assign res_o.done = hit || miss;
  assign res_o.hit  = hit;
  assign res_o.full = (fill_q == FILL_W'(SLOT_COUNT));
  assign res_o.slot = hit ? rd_idx_q : fill_q[SLOT_W-1:0];

endmodule

[hdl/pta_slot_update.sv]
// per-slot counters, flags and sequence store with the read-modify-write update unit
// depends on pta_pkg
`timescale 1ns / 1ps

module pta_slot_update import pta_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  upd_ctl_t          ctl_i,
  input  logic [FLAG_W-1:0] ovf_mask_i,
  output upd_res_t          res_o
);

  logic [COUNT_W-1:0] cnt_mem [CNT_DEPTH];
  logic [SEQ_W-1:0]   seq_mem [SLOT_COUNT];
  logic [FLAG_W-1:0]  flg_mem [SLOT_COUNT];
  logic [CNT_DEPTH-1:0] cnt_vld_q;

  logic [COUNT_W-1:0] cnt_rd_q;
  logic               cnt_ok_q;
  logic [SEQ_W-1:0]   seq_rd_q;
  logic [FLAG_W-1:0]  flg_rd_q;

  logic [CNT_AW-1:0]  addr;
  logic [COUNT_W-1:0] cnt_base;
  logic [SEQ_W-1:0]   seq_base;
  logic [FLAG_W-1:0]  flg_base;
  logic               sat;
  logic [COUNT_W-1:0] cnt_new;
  logic [FLAG_W-1:0]  flg_new;
  logic [SEQ_W-1:0]   seq_new;

  assign addr = CNT_AW'(ctl_i.slot) * CNT_AW'(LEVEL_COUNT) + CNT_AW'(ctl_i.level);

  // counters never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (ctl_i.wr) begin
      cnt_vld_q[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      cnt_rd_q <= cnt_mem[addr];
      cnt_ok_q <= cnt_vld_q[addr];
      seq_rd_q <= seq_mem[ctl_i.slot];
      flg_rd_q <= flg_mem[ctl_i.slot];
    end
    if (ctl_i.wr) begin
      cnt_mem[addr]       <= cnt_new;
      seq_mem[ctl_i.slot] <= seq_new;
      flg_mem[ctl_i.slot] <= flg_new;
    end
  end

  // a freshly claimed slot starts from an empty record
  assign cnt_base = cnt_ok_q ? cnt_rd_q : '0;
  assign seq_base = ctl_i.claim ? '0 : seq_rd_q;
  assign flg_base = ctl_i.claim ? '0 : flg_rd_q;

  assign sat     = (cnt_base == COUNT_MAX);
  assign cnt_new = sat ? cnt_base : cnt_base + COUNT_W'(1);
  assign flg_new = flg_base | (sat ? ovf_mask_i : '0) | ctl_i.flags;
  assign seq_new = (ctl_i.seq > seq_base) ? ctl_i.seq : seq_base;

  assign res_o.count = cnt_new;
  assign res_o.flags = flg_new;
  assign res_o.seq   = seq_new;

endmodule

[hdl/proximity_tag_aggregator.sv]
// a rejected sighting shows its result in the cycle after acceptance; otherwise the
// key scan compares one slot per cycle up to the tag's slot or through all slots in
// use, then a found or newly claimed slot passes the fetch and calc states before the
// result beat, while a full table goes straight to it. one sighting at a time:
// ready returns the cycle after the result beat is taken. reset empties the whole table
// at once (fill count and counter valid bits) and sets overflow_flag_mask to 1.
`timescale 1ns / 1ps

module proximity_tag_aggregator import pta_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ID_W-1:0]      tag_id_i,
  input  logic [LEVEL_W-1:0]   strength_level_i,
  input  logic [FLAG_W-1:0]    sighting_flags_i,
  input  logic [SEQ_W-1:0]     sequence_number_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [OUT_IDX_W-1:0] slot_index_o,
  output logic [COUNT_W-1:0]   level_count_o,
  output logic [FLAG_W-1:0]    slot_flag_bits_o,
  output logic [SEQ_W-1:0]     slot_sequence_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [FLAG_W-1:0]    cfg_wdata_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_FETCH = 5'b00100,
    S_CALC  = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [FLAG_W-1:0]  ovf_mask_q;
  logic [ID_W-1:0]    id_q;
  logic [LVL_W-1:0]   level_q;
  logic [FLAG_W-1:0]  flags_q;
  logic [SEQ_W-1:0]   seq_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               new_q;

  logic [STATUS_W-1:0]  status_q;
  logic [OUT_IDX_W-1:0] idx_q;
  logic [COUNT_W-1:0]   count_q;
  logic [FLAG_W-1:0]    oflags_q;
  logic [SEQ_W-1:0]     oseq_q;

  logic      in_fire;
  logic      bad_in;
  scan_ctl_t scan_ctl;
  scan_res_t scan_res;
  upd_ctl_t  upd_ctl;
  upd_res_t  upd_res;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign bad_in      = (tag_id_i == '0) || (strength_level_i >= LEVEL_W'(LEVEL_COUNT));

  assign scan_ctl.start  = in_fire && !bad_in;
  assign scan_ctl.claim  = (state_q == S_FETCH) && new_q;
  assign scan_ctl.tag_id = id_q;

  assign upd_ctl.rd    = (state_q == S_FETCH);
  assign upd_ctl.wr    = (state_q == S_CALC);
  assign upd_ctl.claim = new_q;
  assign upd_ctl.slot  = slot_q;
  assign upd_ctl.level = level_q;
  assign upd_ctl.flags = flags_q;
  assign upd_ctl.seq   = seq_q;

  pta_key_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (scan_ctl),
    .res_o  (scan_res)
  );

  pta_slot_update u_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (upd_ctl),
    .ovf_mask_i (ovf_mask_q),
    .res_o      (upd_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = bad_in ? S_OUT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_res.done) begin
          state_d = (!scan_res.hit && scan_res.full) ? S_OUT : S_FETCH;
        end
      end
      S_FETCH: state_d = S_CALC;
      S_CALC:  state_d = S_OUT;
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ovf_mask_q <= OVF_MASK_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        ovf_mask_q <= cfg_wdata_i;
      end
    end
  end

  // captured beat, chosen slot and result registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      id_q    <= tag_id_i;
      level_q <= strength_level_i[LVL_W-1:0];
      flags_q <= sighting_flags_i;
      seq_q   <= sequence_number_i;
      if (bad_in) begin
        status_q <= ST_REJECTED;
        idx_q    <= '0;
        count_q  <= '0;
        oflags_q <= '0;
        oseq_q   <= '0;
      end
    end
    if ((state_q == S_SCAN) && scan_res.done) begin
      slot_q <= scan_res.slot;
      new_q  <= !scan_res.hit;
      if (scan_res.hit) begin
        status_q <= ST_EXISTING;
      end else if (scan_res.full) begin
        status_q <= ST_FULL;
        idx_q    <= '0;
        count_q  <= '0;
        oflags_q <= '0;
        oseq_q   <= '0;
      end else begin
        status_q <= ST_CLAIMED;
      end
    end
    if (state_q == S_CALC) begin
      idx_q    <= slot_out(slot_q);
      count_q  <= upd_res.count;
      oflags_q <= upd_res.flags;
      oseq_q   <= upd_res.seq;
    end
  end

  assign status_o         = status_q;
  assign slot_index_o     = idx_q;
  assign level_count_o    = count_q;
  assign slot_flag_bits_o = oflags_q;
  assign slot_sequence_o  = oseq_q;

  a_no_accept_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input accepted while a result is pending");

  a_drop_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_REJECTED || status_o == ST_FULL)) |->
    (slot_index_o == '0 && level_count_o == '0 && slot_flag_bits_o == '0
     && slot_sequence_o == '0))
    else $error("dropped sighting carries nonzero result fields");

  a_scan_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_res.done |-> (state_q == S_SCAN))
    else $error("key scan finished outside the scan phase");

  a_calc_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC) |=> (state_q == S_OUT))
    else $error("update did not lead to a result beat");

  a_updated_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_EXISTING || status_o == ST_CLAIMED)) |->
    (level_count_o != '0))
    else $error("updated slot reports a zero counter");

endmodule
